// ===== rtl/bsae_pkg.sv =====
// Shared constants and types for the block-scaled 4-bit audio encoder.
package bsae_pkg;

    localparam int BLOCK_LEN = 16;
    localparam int ADDR_W    = $clog2(BLOCK_LEN);
    localparam int CNT_W     = $clog2(BLOCK_LEN + 1);
    localparam int MAX_SCALE = 12;
    localparam int SCALE_W   = 4;
    localparam int SAMPLE_W  = 16;
    localparam int CODE_W    = 4;
    localparam int BYTE_W    = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CODE_W-1:0]          code_t;

    // Control from the sequencer to the sample buffer.
    typedef struct packed {
        logic              wr_en;
        logic              clear;
        logic [ADDR_W-1:0] rd_addr;
    } buf_ctrl_t;

endpackage

// ===== rtl/bsae_buffer.sv =====
// Sample memory with fill count and running extremes of the block, zero included.
module bsae_buffer import bsae_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  buf_ctrl_t        ctrl,
    input  sample_t          wr_data,
    output sample_t          rd_data,
    output logic [CNT_W-1:0] fill,
    output sample_t          blk_min,
    output sample_t          blk_max
);

    sample_t          mem [BLOCK_LEN];
    sample_t          rd_data_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    sample_t          min_reg, min_next;
    sample_t          max_reg, max_next;

    // Writes happen only while filling; reads are registered and unconditional, and used only while emitting.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[fill_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[ctrl.rd_addr];
    end

    always_comb begin
        fill_next = fill_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        if (ctrl.clear) begin
            fill_next = '0;
            min_next  = '0;
            max_next  = '0;
        end else if (ctrl.wr_en) begin
            fill_next = fill_reg + CNT_W'(1);
            if (wr_data < min_reg) begin
                min_next = wr_data;
            end
            if (wr_data > max_reg) begin
                max_next = wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;
    assign blk_min = min_reg;
    assign blk_max = max_reg;

endmodule

// ===== rtl/bsae_quant.sv =====
// Scale selection register and per-sample 4-bit quantiser.
module bsae_quant import bsae_pkg::*; (
    input  logic               aclk,
    input  logic               scale_load,
    input  sample_t            blk_min,
    input  sample_t            blk_max,
    input  sample_t            sample,
    output logic [SCALE_W-1:0] scale,
    output code_t              code
);

    localparam int MAG_W   = SAMPLE_W + 1;
    localparam int POS_MAX = 7;
    localparam int NEG_MAX = 8;

    logic [SCALE_W-1:0]      pick;
    logic [SCALE_W-1:0]      scale_reg;
    logic signed [MAG_W-1:0] ext;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        half;
    logic [MAG_W:0]          rnd;
    logic [MAG_W:0]          qm;
    logic                    positive;
    code_t                   lim;
    code_t                   q4;

    // Smallest scale that holds both extremes; clamps at the top scale.
    always_comb begin
        pick = SCALE_W'(MAX_SCALE);
        for (int s = MAX_SCALE - 1; s >= 0; s--) begin
            if ((int'(blk_min) >= -8 * (1 << s)) && (int'(blk_max) <= 7 * (1 << s))) begin
                pick = SCALE_W'(s);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scale_load) begin
            scale_reg <= pick;
        end
    end

    // Round half away from zero on the magnitude, then force non-zero and saturate.
    always_comb begin
        ext      = {sample[SAMPLE_W-1], sample};
        mag      = sample[SAMPLE_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
        half     = (scale_reg == '0) ? '0 : (MAG_W'(1) << (scale_reg - SCALE_W'(1)));
        rnd      = {1'b0, mag} + {1'b0, half};
        qm       = rnd >> scale_reg;
        positive = !sample[SAMPLE_W-1] && (sample != '0);
        lim      = positive ? CODE_W'(POS_MAX) : CODE_W'(NEG_MAX);
        if (qm == '0) begin
            q4 = CODE_W'(1);
        end else if (qm > (MAG_W+1)'(lim)) begin
            q4 = lim;
        end else begin
            q4 = qm[CODE_W-1:0];
        end
        code = positive ? q4 : q4 + CODE_W'(POS_MAX);
    end

    assign scale = scale_reg;

endmodule

// ===== rtl/block_scaled_4bit_audio_encoder.sv =====
// Top level: sequencer and output register of the block-scaled 4-bit audio encoder.
// Input takes one sample word per cycle while a block fills; after the word that
// completes the block (full, or marked by s_tlast) the input stalls while it is emitted.
// The header word passes through the scale state, the header state and the output
// register after that word, then the code words follow, each packing two samples read
// from memory, as m_tready allows. Reset (aresetn low at a clock edge) empties the block,
// clears the extremes and drops m_tvalid; the memory keeps its contents.
module block_scaled_4bit_audio_encoder import bsae_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] is_header, [1] stream_done
    output logic        m_tlast    // block_done
);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_SCALE,
        ST_HDR,
        ST_HI,
        ST_LO
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   n_reg, n_next;        // samples in the block being emitted
    logic [CNT_W-1:0]   idx_reg, idx_next;    // index of the high-nibble sample
    logic               eos_reg, eos_next;
    code_t              hi_reg, hi_next;
    logic               vld_reg, vld_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               hdr_reg, hdr_next;
    logic               bdone_reg, bdone_next;
    logic               sdone_reg, sdone_next;

    buf_ctrl_t          bctl;
    sample_t            rd_data;
    logic [CNT_W-1:0]   fill;
    sample_t            blk_min;
    sample_t            blk_max;
    logic [SCALE_W-1:0] scale;
    code_t              code;
    logic               scale_load;

    logic               in_acc;
    logic               out_free;
    logic [CNT_W-1:0]   fill_inc;
    logic [CNT_W-1:0]   idx_p1;
    logic [CNT_W-1:0]   idx_p2;
    logic               last_word;

    bsae_buffer u_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bctl),
        .wr_data (sample_t'(s_tdata)),
        .rd_data (rd_data),
        .fill    (fill),
        .blk_min (blk_min),
        .blk_max (blk_max)
    );

    bsae_quant u_quant (
        .aclk       (aclk),
        .scale_load (scale_load),
        .blk_min    (blk_min),
        .blk_max    (blk_max),
        .sample     (rd_data),
        .scale      (scale),
        .code       (code)
    );

    assign s_tready  = (state_reg == ST_FILL);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !vld_reg || m_tready;
    assign fill_inc  = fill + CNT_W'(1);
    assign idx_p1    = idx_reg + CNT_W'(1);
    assign idx_p2    = idx_reg + CNT_W'(2);
    assign last_word = (idx_p2 >= n_reg);

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        eos_next     = eos_reg;
        hi_next      = hi_reg;
        vld_next     = vld_reg && !m_tready;
        byte_next    = byte_reg;
        hdr_next     = hdr_reg;
        bdone_next   = bdone_reg;
        sdone_next   = sdone_reg;
        scale_load   = 1'b0;
        bctl.wr_en   = 1'b0;
        bctl.clear   = 1'b0;
        bctl.rd_addr = '0;

        case (state_reg)
            ST_FILL: begin
                bctl.wr_en = in_acc;
                if (in_acc && (s_tlast || (fill_inc == CNT_W'(BLOCK_LEN)))) begin
                    n_next     = fill_inc;
                    eos_next   = s_tlast;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // extremes now include the final sample
                scale_load = 1'b1;
                state_next = ST_HDR;
            end
            ST_HDR: begin
                bctl.rd_addr = '0;
                if (out_free) begin
                    vld_next   = 1'b1;
                    byte_next  = {scale, 4'b0000};
                    hdr_next   = 1'b1;
                    bdone_next = 1'b0;
                    sdone_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                hi_next      = code;
                bctl.rd_addr = idx_p1[ADDR_W-1:0];
                state_next   = ST_LO;
            end
            ST_LO: begin
                // hold the low-sample address while stalled, else fetch the next pair's high sample
                bctl.rd_addr = out_free ? idx_p2[ADDR_W-1:0] : idx_p1[ADDR_W-1:0];
                if (out_free) begin
                    vld_next   = 1'b1;
                    byte_next  = {hi_reg, (idx_p1 < n_reg) ? code : code_t'(0)};
                    hdr_next   = 1'b0;
                    bdone_next = last_word;
                    sdone_next = last_word && eos_reg;
                    if (last_word) begin
                        bctl.clear = 1'b1;
                        state_next = ST_FILL;
                    end else begin
                        idx_next   = idx_p2;
                        state_next = ST_HI;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        eos_reg   <= eos_next;
        hi_reg    <= hi_next;
        byte_reg  <= byte_next;
        hdr_reg   <= hdr_next;
        bdone_reg <= bdone_next;
        sdone_reg <= sdone_next;
    end

    assign m_tvalid   = vld_reg;
    assign m_tdata    = byte_reg;
    assign m_tuser[0] = hdr_reg;
    assign m_tuser[1] = sdone_reg;
    assign m_tlast    = bdone_reg;

    // The buffer never takes a word once it is full.
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (fill < CNT_W'(BLOCK_LEN)))
        else $error("sample accepted into a full buffer");

    // A header carries a legal scale and a zero filter nibble, and never ends a block.
    a_header_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            ((m_tdata[7:4] <= SCALE_W'(MAX_SCALE)) && (m_tdata[3:0] == 4'b0000) && !m_tlast))
        else $error("malformed header word");

    // End of stream is flagged only on the closing word of a block.
    a_stream_on_block_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("stream_done without block_done");

    // Input reopens only after the closing word of a block has been loaded.
    a_reopen_after_close: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) |-> (m_tvalid && m_tlast))
        else $error("input reopened before block closed");

endmodule
